[hw/rtl/atmf_pkg.sv]
package atmf_pkg;

    // Frame store and window geometry.
    localparam int MAX_ROWS   = 64;
    localparam int MAX_COLS   = 64;
    localparam int MAX_RADIUS = 3;
    localparam int PIXEL_BITS = 8;
    localparam int ROW_BITS   = 6;
    localparam int COL_BITS   = 6;

    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    localparam logic [1:0] REG_ROWS   = 2'd0;
    localparam logic [1:0] REG_COLS   = 2'd1;
    localparam logic [1:0] REG_RADIUS = 2'd2;
    localparam logic [1:0] REG_TRIM   = 2'd3;

    localparam logic [1:0] STATUS_OK    = 2'd0;
    localparam logic [1:0] STATUS_SMALL = 2'd1;
    localparam logic [1:0] STATUS_RANGE = 2'd2;

    localparam int CFG_BITS  = 7;
    localparam int TRIM_BITS = 5;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic start;      // latch the query and clear the gather state
        logic gather;     // one window read step
        logic clear_rank; // reset the rank scan for the next candidate
        logic rank;       // one rank compare step
        logic accum;      // fold the ranked value into the sum
        logic div_start;  // load the divider
        logic div_step;   // one quotient bit
    } atmf_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic out_range;
        logic too_small;
        logic gather_done;
        logic rank_done;
        logic cand_done;
        logic div_done;
    } atmf_stat_t;

endpackage

[hw/rtl/alpha_trimmed_mean_filter_top.sv]
// Alpha-trimmed mean filter with a 64x64 frame store. A write request
// (opcode 0) stores one pixel and gives no result. A query request (opcode 1)
// gathers the border-clipped window around the named pixel, ranks the values,
// drops trim_count from each end and returns the truncated mean, with status
// 1 when the window is too small for the trim and status 2 when the position
// lies outside the image. A query runs through a check of the position, a
// read of the window through the single frame store read port, a rank of each
// of the n values (one registered compare per cycle, which dominates), a
// divider load, a restoring division at one quotient bit per cycle, and a
// load of the result register. A query out of range skips from the check to
// the result, and a window too small for the trim skips from the read to the
// result. Only one query is in flight; the next request is taken in the cycle
// after the result is loaded, and a query waits for the result register to be
// free before loading its own result.
// Configuration writes must arrive only while the block is idle.
module alpha_trimmed_mean_filter_top
    import atmf_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // row[5:0], col[5:0], pixel_in[7:0], zero pad
    input  logic        s_tuser,   // opcode
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // filtered_value[7:0]
    output logic [1:0]  m_tuser,   // status[1:0]
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [6:0]  cfg_data
);

    logic [6:0] rows_reg, cols_reg;
    logic [1:0] radius_reg;
    logic [4:0] trim_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rows_reg   <= 7'd64;
            cols_reg   <= 7'd64;
            radius_reg <= 2'd1;
            trim_reg   <= 5'd0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_ROWS:   rows_reg   <= cfg_data;
                REG_COLS:   cols_reg   <= cfg_data;
                REG_RADIUS: radius_reg <= cfg_data[1:0];
                REG_TRIM:   trim_reg   <= cfg_data[4:0];
                default:    ;
            endcase
        end
    end

    atmf_cmd_t  cmd;
    atmf_stat_t stat;
    logic       busy, out_err, accept;
    logic [7:0] result;
    logic [1:0] status_reg;

    // Input is taken when idle; the result register is separate so a
    // pending result does not block new write requests.
    assign s_tready = !busy;
    assign accept   = s_tvalid && s_tready;

    atmf_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .query     (accept && (s_tuser == OP_QUERY)),
        .stat      (stat),
        .out_ready (m_tready),
        .cmd       (cmd),
        .busy      (busy),
        .out_valid (m_tvalid),
        .out_err   (out_err)
    );

    atmf_dp u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .wr_en      (accept && (s_tuser == OP_WRITE)),
        .wr_row     (s_tdata[5:0]),
        .wr_col     (s_tdata[11:6]),
        .wr_pixel   (PIXEL_BITS'(s_tdata[19:12])),
        .q_row      (s_tdata[5:0]),
        .q_col      (s_tdata[11:6]),
        .rows_cfg   (rows_reg),
        .cols_cfg   (cols_reg),
        .radius_cfg (radius_reg),
        .trim_cfg   (trim_reg),
        .cmd        (cmd),
        .stat       (stat),
        .result     (result)
    );

    // The status code is settled while the query runs.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            status_reg <= STATUS_OK;
        end
        else if (cmd.start)
        begin
            status_reg <= STATUS_OK;
        end
        else if (busy && stat.out_range && !cmd.gather && !cmd.rank)
        begin
            status_reg <= STATUS_RANGE;
        end
        else if (cmd.gather && stat.gather_done && stat.too_small)
        begin
            status_reg <= STATUS_SMALL;
        end
    end

    logic [7:0] value_reg;
    logic [1:0] out_status_reg;
    always_ff @(posedge clk)
    begin
        if (!m_tvalid || m_tready)
        begin
            value_reg      <= out_err ? 8'd0 : result;
            out_status_reg <= out_err ? status_reg : STATUS_OK;
        end
    end

    assign m_tdata = value_reg;
    assign m_tuser = out_status_reg;

    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result dropped under stall");
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.start |=> busy)
        else $error("query start did not enter busy");
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tuser <= STATUS_RANGE))
        else $error("illegal status code");

endmodule

[hw/rtl/atmf_ctrl.sv]
module atmf_ctrl
    import atmf_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       query,
    input  atmf_stat_t stat,
    input  logic       out_ready,
    output atmf_cmd_t  cmd,
    output logic       busy,
    output logic       out_valid,
    output logic       out_err
);

    typedef enum logic [2:0] {
        S_IDLE, S_CHECK, S_GATHER, S_RANK, S_DIVLD, S_DIV, S_OUT
    } state_t;

    state_t state_reg, state_next;
    logic   valid_reg, valid_next;
    logic   err_reg, err_next;

    always_comb
    begin
        state_next = state_reg;
        valid_next = valid_reg;
        err_next   = err_reg;
        cmd        = '0;
        if (valid_reg && out_ready)
        begin
            valid_next = 1'b0;
        end
        case (state_reg)
            S_IDLE:
            begin
                if (query)
                begin
                    cmd.start  = 1'b1;
                    state_next = S_CHECK;
                end
            end
            S_CHECK:
            begin
                if (stat.out_range)
                begin
                    err_next   = 1'b1;
                    state_next = S_OUT;
                end
                else
                begin
                    state_next = S_GATHER;
                end
            end
            S_GATHER:
            begin
                cmd.gather = 1'b1;
                if (stat.gather_done)
                begin
                    cmd.clear_rank = 1'b1;
                    if (stat.too_small)
                    begin
                        err_next   = 1'b1;
                        state_next = S_OUT;
                    end
                    else
                    begin
                        state_next = S_RANK;
                    end
                end
            end
            S_RANK:
            begin
                cmd.rank = 1'b1;
                if (stat.rank_done)
                begin
                    cmd.accum      = 1'b1;
                    cmd.clear_rank = 1'b1;
                    if (stat.cand_done)
                    begin
                        state_next = S_DIVLD;
                    end
                end
            end
            S_DIVLD:
            begin
                cmd.div_start = 1'b1;
                state_next    = S_DIV;
            end
            S_DIV:
            begin
                cmd.div_step = 1'b1;
                if (stat.div_done)
                begin
                    err_next   = 1'b0;
                    state_next = S_OUT;
                end
            end
            S_OUT:
            begin
                if (!valid_reg || out_ready)
                begin
                    valid_next = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            valid_reg <= 1'b0;
            err_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            valid_reg <= valid_next;
            err_reg   <= err_next;
        end
    end

    assign busy      = (state_reg != S_IDLE);
    assign out_valid = valid_reg;
    assign out_err   = err_reg;

endmodule

[hw/rtl/atmf_dp.sv]
module atmf_dp
    import atmf_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  wr_en,
    input  logic [ROW_BITS-1:0]   wr_row,
    input  logic [COL_BITS-1:0]   wr_col,
    input  logic [PIXEL_BITS-1:0] wr_pixel,
    input  logic [ROW_BITS-1:0]   q_row,
    input  logic [COL_BITS-1:0]   q_col,
    input  logic [CFG_BITS-1:0]   rows_cfg,
    input  logic [CFG_BITS-1:0]   cols_cfg,
    input  logic [1:0]            radius_cfg,
    input  logic [TRIM_BITS-1:0]  trim_cfg,
    input  atmf_cmd_t             cmd,
    output atmf_stat_t            stat,
    output logic [7:0]            result
);

    localparam int RB    = ROW_BITS;
    localparam int CB    = COL_BITS;
    localparam int SIDE  = 2 * MAX_RADIUS + 1;
    localparam int WMAX  = SIDE * SIDE;
    localparam int NB    = $clog2(WMAX + 1);
    localparam int IB    = (WMAX > 1) ? $clog2(WMAX) : 1;
    localparam int SB    = NB + PIXEL_BITS;
    localparam int DEPTH = MAX_ROWS * MAX_COLS;
    localparam int AB    = RB + CB;
    localparam int KB    = (RB > CB ? RB : CB) + 2;

    logic [PIXEL_BITS-1:0] mem [DEPTH];
    logic [PIXEL_BITS-1:0] rd_data_reg;
    logic [PIXEL_BITS-1:0] win_reg [WMAX];

    logic [RB-1:0] qr_reg;
    logic [CB-1:0] qc_reg;
    logic [KB-1:0] rows_s, cols_s, rad_s;
    logic [KB-1:0] r0, r1, c0, c1;
    logic [KB-1:0] ri_reg, ci_reg;
    logic          rd_pend_reg;
    logic          addr_done_reg;
    logic [NB-1:0] n_reg;
    logic [IB-1:0] cand_reg, scan_reg;
    logic [IB-1:0] scan_idx_reg;
    logic [PIXEL_BITS-1:0] scan_val_reg;
    logic [PIXEL_BITS-1:0] cand_val_reg;
    logic          cmp_vld_reg;
    logic [NB-1:0] below_reg;
    logic [SB-1:0] sum_reg;
    logic [SB-1:0] rem_reg;
    logic [SB-1:0] quo_reg;
    logic [NB-1:0] den_reg;
    logic [$clog2(SB+1)-1:0] bit_reg;
    logic [NB:0]   trim2;
    logic          write_ok;

    always_comb
    begin
        rows_s = (KB'(rows_cfg) > KB'(MAX_ROWS)) ? KB'(MAX_ROWS) : KB'(rows_cfg);
        cols_s = (KB'(cols_cfg) > KB'(MAX_COLS)) ? KB'(MAX_COLS) : KB'(cols_cfg);
        rad_s  = (KB'(radius_cfg) > KB'(MAX_RADIUS)) ? KB'(MAX_RADIUS)
                                                     : KB'(radius_cfg);
        r0 = (KB'(qr_reg) >= rad_s) ? KB'(qr_reg) - rad_s : '0;
        c0 = (KB'(qc_reg) >= rad_s) ? KB'(qc_reg) - rad_s : '0;
        r1 = (KB'(qr_reg) + rad_s < rows_s) ? KB'(qr_reg) + rad_s : rows_s - 1'b1;
        c1 = (KB'(qc_reg) + rad_s < cols_s) ? KB'(qc_reg) + rad_s : cols_s - 1'b1;
        trim2 = (NB+1)'({trim_cfg, 1'b0});
    end

    assign write_ok = (KB'(wr_row) < KB'(MAX_ROWS)) && (KB'(wr_col) < KB'(MAX_COLS));

    // Frame store: one write port, one registered read port.
    always_ff @(posedge clk)
    begin
        if (wr_en && write_ok)
        begin
            mem[AB'({wr_row, wr_col})] <= wr_pixel;
        end
        rd_data_reg <= mem[AB'({ri_reg[RB-1:0], ci_reg[CB-1:0]})];
    end

    // Rank selection: the value at sorted position p is the one with
    // exactly p smaller-or-tied-earlier elements; each window entry
    // is ranked by a scan, so entries with trim <= rank < n-trim are summed.
    // Window entries are read into registers, so each compare works on the
    // entry that its scan address named in the cycle before.
    logic           less;
    logic [NB-1:0]  rank_next;
    assign less = (scan_val_reg < cand_val_reg) ||
                  ((scan_val_reg == cand_val_reg) && (scan_idx_reg < cand_reg));
    assign rank_next = below_reg + NB'(less);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_pend_reg   <= 1'b0;
            addr_done_reg <= 1'b0;
        end
        else if (cmd.start)
        begin
            rd_pend_reg   <= 1'b0;
            addr_done_reg <= 1'b0;
        end
        else if (cmd.gather)
        begin
            rd_pend_reg <= !addr_done_reg;
            if (!addr_done_reg && ci_reg == c1 && ri_reg == r1)
            begin
                addr_done_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.start)
        begin
            qr_reg <= q_row;
            qc_reg <= q_col;
            n_reg  <= '0;
        end
        else if (cmd.gather)
        begin
            if (rd_pend_reg)
            begin
                win_reg[n_reg[IB-1:0]] <= rd_data_reg;
                n_reg <= n_reg + 1'b1;
            end
        end
        if (stat.out_range == 1'b0 && !cmd.gather && !cmd.start && !rd_pend_reg
            && !addr_done_reg && n_reg == '0)
        begin
            ri_reg <= r0;
            ci_reg <= c0;
        end
        else if (cmd.gather && !addr_done_reg)
        begin
            if (ci_reg == c1)
            begin
                ci_reg <= c0;
                ri_reg <= ri_reg + 1'b1;
            end
            else
            begin
                ci_reg <= ci_reg + 1'b1;
            end
        end
        if (cmd.start)
        begin
            sum_reg  <= '0;
            cand_reg <= '0;
        end
        if (cmd.clear_rank)
        begin
            scan_reg    <= '0;
            below_reg   <= '0;
            cmp_vld_reg <= 1'b0;
        end
        else if (cmd.rank)
        begin
            scan_reg     <= scan_reg + 1'b1;
            scan_idx_reg <= scan_reg;
            scan_val_reg <= win_reg[scan_reg];
            cmp_vld_reg  <= 1'b1;
            if (cmp_vld_reg)
            begin
                below_reg <= rank_next;
            end
        end
        cand_val_reg <= win_reg[cand_reg];
        if (cmd.accum)
        begin
            if (rank_next >= NB'(trim_cfg) &&
                (NB+1)'(rank_next) + (NB+1)'(trim_cfg) < (NB+1)'(n_reg))
            begin
                sum_reg <= sum_reg + SB'(cand_val_reg);
            end
            cand_reg <= cand_reg + 1'b1;
        end
        if (cmd.div_start)
        begin
            rem_reg <= '0;
            quo_reg <= sum_reg;
            den_reg <= NB'((NB+1)'(n_reg) - trim2);
            bit_reg <= '0;
        end
        else if (cmd.div_step)
        begin
            if ({rem_reg[SB-2:0], quo_reg[SB-1]} >= SB'(den_reg))
            begin
                rem_reg <= {rem_reg[SB-2:0], quo_reg[SB-1]} - SB'(den_reg);
                quo_reg <= {quo_reg[SB-2:0], 1'b1};
            end
            else
            begin
                rem_reg <= {rem_reg[SB-2:0], quo_reg[SB-1]};
                quo_reg <= {quo_reg[SB-2:0], 1'b0};
            end
            bit_reg <= bit_reg + 1'b1;
        end
    end

    always_comb
    begin
        stat.out_range   = (KB'(qr_reg) >= rows_s) || (KB'(qc_reg) >= cols_s);
        stat.gather_done = addr_done_reg && !rd_pend_reg;
        stat.too_small   = ((NB+1)'(n_reg) <= trim2);
        stat.rank_done   = cmp_vld_reg && (NB'(scan_idx_reg) == n_reg - 1'b1);
        stat.cand_done   = (NB'(cand_reg) == n_reg - 1'b1);
        stat.div_done    = (bit_reg == $bits(bit_reg)'(SB - 1));
    end

    assign result = 8'(quo_reg);

endmodule

[sim/alpha_trimmed_mean_filter_top_tb.sv]
`timescale 1ns / 1ps

// Stream-level testbench for the alpha-trimmed mean filter. Write and query
// requests flow from a pending queue through a clocked driver. Every accepted
// query is predicted right away against a local copy of the frame store and
// the register settings. The monitor compares each result, field by field,
// with the oldest prediction.
module alpha_trimmed_mean_filter_top_tb;
    import atmf_pkg::*;

    localparam int   STALL_LIMIT = 20000;
    localparam int   IDLE_PCT = 21;
    localparam int   ITEM_GOAL = 950;

    // One request waiting for the driver.
    typedef struct packed {
        logic [7:0] pixel;
        logic [5:0] col;
        logic [5:0] row;
        logic       op;
    } pix_req_t;

    typedef struct {
        logic [7:0] value;
        logic [1:0] status;
    } filt_res_t;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [23:0] s_tdata;   // row[5:0], col[5:0], pixel_in[7:0], zero pad
    logic        s_tuser;   // opcode
    logic        m_tvalid;
    logic        m_tready;
    logic [7:0]  m_tdata;   // filtered_value[7:0]
    logic [1:0]  m_tuser;   // status[1:0]
    logic        cfg_we;
    logic [1:0]  cfg_index;
    logic [6:0]  cfg_data;

    alpha_trimmed_mean_filter_top uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // Requests waiting for the driver, and predicted filter results.
    pix_req_t  pending_reqs[$];
    filt_res_t expected_means[$];

    // Local copy of the block: frame store and register settings.
    logic [7:0] frame_copy[4096];
    // Pixels already scheduled for writing, so no query reads an unwritten one.
    bit         scheduled[4096];
    int         rows_reg;
    int         cols_reg;
    int         radius_reg;
    int         trim_reg;

    pix_req_t   cur_req;
    int         errors;
    int         n_writes;
    int         n_queries;
    int         n_status[3];
    int         n_queued;
    int         stall_count;
    bit         calm;
    bit         hold_go;
    int         hold_left;

    always
    begin
        clk = 1'b1;
        #4;
        clk = 1'b0;
        #4;
    end

    // Work out the filter result for a query at (r, c) from the local state.
    function automatic filt_res_t predict_mean(int r, int c);
        int        rows;
        int        cols;
        int        rad;
        int        r0;
        int        r1;
        int        c0;
        int        c1;
        int        n;
        int        sum;
        int        t;
        int        k;
        int        win[49];
        filt_res_t res;
        rows = (rows_reg > 64) ? 64 : rows_reg;
        cols = (cols_reg > 64) ? 64 : cols_reg;
        rad  = radius_reg;
        res.value = 8'd0;
        if (r >= rows || c >= cols)
        begin
            res.status = STATUS_RANGE;
            return res;
        end
        r0 = (r >= rad) ? r - rad : 0;
        r1 = (r + rad < rows) ? r + rad : rows - 1;
        c0 = (c >= rad) ? c - rad : 0;
        c1 = (c + rad < cols) ? c + rad : cols - 1;
        n = 0;
        for (int i = r0; i <= r1; i++)
            for (int j = c0; j <= c1; j++)
            begin
                win[n] = frame_copy[i * 64 + j];
                n++;
            end
        if (n <= 2 * trim_reg)
        begin
            res.status = STATUS_SMALL;
            return res;
        end
        for (int i = 1; i < n; i++)
        begin
            t = win[i];
            k = i;
            while (k > 0 && win[k - 1] > t)
            begin
                win[k] = win[k - 1];
                k--;
            end
            win[k] = t;
        end
        sum = 0;
        for (int i = trim_reg; i < n - trim_reg; i++)
            sum += win[i];
        res.value  = 8'(sum / (n - 2 * trim_reg));
        res.status = STATUS_OK;
        return res;
    endfunction

    // Driver: a request is held until taken; on acceptance a write updates the
    // local frame store and a query gets its result predicted.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            s_tdata  <= '0;
            s_tuser  <= 1'b0;
        end
        else if (!(s_tvalid && !s_tready))
        begin
            if (s_tvalid)
            begin
                if (cur_req.op == OP_WRITE)
                begin
                    frame_copy[cur_req.row * 64 + cur_req.col] = cur_req.pixel;
                    n_writes++;
                end
                else
                begin
                    expected_means.insert(expected_means.size(),
                                          predict_mean(cur_req.row, cur_req.col));
                    n_queries++;
                end
            end
            if (pending_reqs.size() > 0 && (calm || $urandom_range(99) >= IDLE_PCT))
            begin
                cur_req = pending_reqs.pop_front();
                s_tvalid <= 1'b1;
                s_tdata  <= {4'b0000, cur_req.pixel, cur_req.col, cur_req.row};
                s_tuser  <= cur_req.op;
            end
            else
                s_tvalid <= 1'b0;
        end
    end

    // Monitor: checks each result and drives the random and long back-pressure.
    always @(posedge clk or negedge rst_n)
    begin
        filt_res_t want;
        if (!rst_n)
            m_tready <= 1'b0;
        else
        begin
            if (m_tvalid && m_tready)
            begin
                if (expected_means.size() == 0)
                begin
                    errors++;
                    if (errors <= 10)
                        $display("ERROR: unexpected result value=%0d status=%0d",
                                 m_tdata, m_tuser);
                end
                else
                begin
                    want = expected_means.pop_front();
                    n_status[want.status]++;
                    if (m_tdata !== want.value || m_tuser !== want.status)
                    begin
                        errors++;
                        if (errors <= 10)
                            $display({"ERROR: result %0d: expected value=%0d status=%0d,",
                                      " got value=%0d status=%0d"},
                                     n_status[0] + n_status[1] + n_status[2],
                                     want.value, want.status, m_tdata, m_tuser);
                    end
                end
            end
            if (hold_go)
            begin
                hold_go = 1'b0;
                hold_left = 600;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                m_tready <= 1'b0;
            end
            else
                m_tready <= calm || $urandom_range(99) >= IDLE_PCT;
        end
    end

    // Watchdog: counts cycles in which no request and no result moves.
    always @(posedge clk)
    begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we)
            stall_count <= 0;
        else if (stall_count >= STALL_LIMIT)
        begin
            $display("ERROR: no progress for %0d cycles", STALL_LIMIT);
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
        else
            stall_count <= stall_count + 1;
    end

    // Waits until all queued requests are taken and every result has come,
    // then lets the block drain its last write.
    task automatic wait_drained();
        do
            @(negedge clk);
        while (pending_reqs.size() > 0 || s_tvalid || expected_means.size() > 0);
        repeat (40) @(negedge clk);
    endtask

    task automatic write_reg(logic [1:0] idx, int val);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= 7'(val);
        @(posedge clk);
        cfg_we    <= 1'b0;
        case (idx)
            REG_ROWS:   rows_reg   = val & 8'h7f;
            REG_COLS:   cols_reg   = val & 8'h7f;
            REG_RADIUS: radius_reg = val & 3;
            REG_TRIM:   trim_reg   = val & 5'h1f;
            default:    ;
        endcase
    endtask

    task automatic set_regs(int rows, int cols, int rad, int trim);
        write_reg(REG_ROWS, rows);
        write_reg(REG_COLS, cols);
        write_reg(REG_RADIUS, rad);
        write_reg(REG_TRIM, trim);
        @(negedge clk);
    endtask

    task automatic push_write(int r, int c, int val);
        pix_req_t req;
        req.op    = OP_WRITE;
        req.row   = 6'(r);
        req.col   = 6'(c);
        req.pixel = 8'(val);
        pending_reqs.insert(pending_reqs.size(), req);
        scheduled[r * 64 + c] = 1'b1;
        n_queued++;
    endtask

    function automatic int rand_pixel();
        case ($urandom_range(9))
            0: return 0;
            1: return 255;
            default: return $urandom_range(255);
        endcase
    endfunction

    // Queues a query, preceded by writes for any pixel of its clipped window
    // that has never been written.
    task automatic push_query(int r, int c);
        int       rows;
        int       cols;
        pix_req_t req;
        rows = (rows_reg > 64) ? 64 : rows_reg;
        cols = (cols_reg > 64) ? 64 : cols_reg;
        if (r < rows && c < cols)
            for (int i = r - radius_reg; i <= r + radius_reg; i++)
                for (int j = c - radius_reg; j <= c + radius_reg; j++)
                    if (i >= 0 && i < rows && j >= 0 && j < cols &&
                        !scheduled[i * 64 + j])
                        push_write(i, j, rand_pixel());
        req.op    = OP_QUERY;
        req.row   = 6'(r);
        req.col   = 6'(c);
        req.pixel = 8'($urandom_range(255));
        pending_reqs.insert(pending_reqs.size(), req);
        n_queued++;
    endtask

    // A random mix of writes and queries for the current settings. Most
    // queries fall inside the image; some land outside on purpose.
    task automatic random_burst(int count);
        int rows;
        int cols;
        int pick;
        rows = (rows_reg > 64) ? 64 : rows_reg;
        cols = (cols_reg > 64) ? 64 : cols_reg;
        for (int k = 0; k < count; k++)
        begin
            pick = $urandom_range(99);
            if (pick < 30)
                push_write($urandom_range(rows - 1), $urandom_range(cols - 1), rand_pixel());
            else if (pick < 38)
                push_write($urandom_range(63), $urandom_range(63), rand_pixel());
            else if (pick < 48)
                push_query($urandom_range(63), $urandom_range(63));
            else
                push_query($urandom_range(rows - 1), $urandom_range(cols - 1));
        end
    endtask

    initial
    begin
        int rows;
        int cols;
        int rad;
        int trim;
        int phase;
        rst_n     = 1'b0;
        cfg_we    = 1'b0;
        cfg_index = '0;
        cfg_data  = '0;
        errors    = 0;
        n_writes  = 0;
        n_queries = 0;
        n_queued  = 0;
        n_status  = '{0, 0, 0};
        calm      = 1'b0;
        hold_go   = 1'b0;
        hold_left = 0;
        rows_reg  = 64;
        cols_reg  = 64;
        radius_reg = 1;
        trim_reg  = 0;
        foreach (scheduled[i])
            scheduled[i] = 1'b0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Reset settings: corners of the full frame and extreme pixel values.
        push_write(0, 0, 255);
        push_write(0, 1, 0);
        push_write(63, 63, 255);
        push_query(0, 0);
        push_query(63, 63);
        push_query(0, 63);
        push_query(63, 0);
        wait_drained();

        // Sizes above the frame store saturate; the largest trim that the
        // full window allows, and a corner window that is too small for it.
        set_regs(127, 127, 3, 24);
        push_query(31, 31);
        push_query(63, 63);
        push_query(3, 60);
        wait_drained();

        // A zero row count puts every query out of range.
        set_regs(0, 5, 2, 0);
        push_query(0, 0);
        push_write(40, 40, 17);
        wait_drained();
        set_regs(5, 0, 2, 0);
        push_query(2, 2);
        wait_drained();

        // A one-pixel image with no window; a position off that pixel.
        set_regs(1, 1, 0, 0);
        push_query(0, 0);
        push_query(0, 1);
        push_query(1, 0);
        wait_drained();

        // The widest trim field always leaves the window too small.
        set_regs(64, 64, 3, 31);
        push_query(10, 10);
        wait_drained();

        // Random phases with varied settings, mostly small images so that
        // queries stay short. One phase runs without idling, and one holds
        // the result side off long enough to back the block up.
        phase = 0;
        while (n_queued < ITEM_GOAL)
        begin
            rows = ($urandom_range(9) == 0) ? $urandom_range(17, 64) : $urandom_range(1, 16);
            cols = ($urandom_range(9) == 0) ? $urandom_range(17, 64) : $urandom_range(1, 16);
            rad  = ($urandom_range(3) == 0) ? 3 : $urandom_range(2);
            trim = ($urandom_range(4) == 0) ? $urandom_range(31) : $urandom_range(4);
            set_regs(rows, cols, rad, trim);
            calm = (phase == 2);
            if (phase == 4)
                hold_go = 1'b1;
            random_burst($urandom_range(30, 70));
            wait_drained();
            calm = 1'b0;
            phase++;
        end

        $display("Covered %0d writes and %0d queries over %0d random setting phases.",
                 n_writes, n_queries, phase);
        $display("Results by status: %0d ok, %0d window too small, %0d out of range.",
                 n_status[0], n_status[1], n_status[2]);
        if (errors == 0)
            $display("Testbench completed without errors");
        else
        begin
            $display("%0d mismatches in total", errors);
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
